// ===== design/qpc_pkg.sv =====
`default_nettype none
package qpc_pkg;

  localparam int unsigned PPR_W         = 16;
  localparam int unsigned REV_W         = 32;
  localparam int unsigned DIR_W         = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned IN_DATA_W     = 8;
  localparam int unsigned OUT_DATA_W    = 56;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned EDGES_DEFAULT = 4;

  localparam logic [PPR_W-1:0] PPR_RESET = 16'd1024;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PPR     = 2'd0,
    CFG_INVERT  = 2'd1,
    CFG_INDEX   = 2'd2,
    CFG_ENABLED = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ZERO = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     has_step;
    logic     step_up;
    logic     z_load;
    logic     z_val;
  } op_t;

  typedef struct packed {
    logic                  wr;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Step of an AB transition: DIR_UP, DIR_DOWN or DIR_NONE for unchanged or invalid.
  function automatic logic [DIR_W-1:0] step_lookup(input logic [1:0] prev_ab,
                                                   input logic [1:0] ab);
    logic [DIR_W-1:0] d;
    d = DIR_NONE;
    case ({prev_ab, ab})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: d = DIR_DOWN;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: d = DIR_UP;
      default: d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/quadrature_position_counter_top.sv =====
// Channel  Dir  Handshake             Payload
// s_*      in   s_tvalid / s_tready   tuser: cmd; tdata: level_a, level_b, level_z
// m_*      out  m_tvalid / m_tready   tdata: count_in_rev, rev_count, last_dir, index_seen
// cfg_*    in   cfg_valid / cfg_ready cfg_index: register, cfg_data: value
//
// One item per clock sustained while m_tready stays high; each item passes front
// decode, the two-entry queue and the back update with its output register.
// rst is synchronous; ppr resets to 1024 counts per rev, other control state to zero.
// A stalled m_tready fills the queue, after which s_tready drops.
// cfg_ready is always high; writes are expected only while the block is idle.
`default_nettype none
module quadrature_position_counter_top #(
  parameter int unsigned EDGES_PER_COUNT = qpc_pkg::EDGES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [qpc_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] level_a, [1] level_b, [2] level_z
  input  wire logic                             s_tuser,   // [0] cmd
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [qpc_pkg::OUT_DATA_W-1:0]        m_tdata,   // [15:0] count_in_rev, [47:16] rev_count,
                                                           // [49:48] last_dir, [50] index_seen
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [qpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [qpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  qpc_pkg::cfg_wr_t          cfg;
  qpc_pkg::op_t              front_op;
  qpc_pkg::op_t              back_op;
  logic                      back_valid;
  logic                      back_ready;
  logic [qpc_pkg::PPR_W-1:0] out_pos;
  logic [qpc_pkg::REV_W-1:0] out_rev;
  logic [qpc_pkg::DIR_W-1:0] out_dir;
  logic                      out_z;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.idx   = qpc_pkg::cfg_reg_t'(cfg_index);
  assign cfg.data  = cfg_data;

  assign m_tdata = {5'b00000, out_z, out_dir, out_rev, out_pos};

  qpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_a     (s_tdata[0]),
    .in_b     (s_tdata[1]),
    .in_z     (s_tdata[2]),
    .q_ready  (s_tready),
    .op       (front_op)
  );

  qpc_queue #(
    .DEPTH (qpc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (front_op),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_op    (back_op)
  );

  qpc_back #(
    .EDGES_PER_COUNT (EDGES_PER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (back_valid),
    .op_ready  (back_ready),
    .op        (back_op),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pos   (out_pos),
    .out_rev   (out_rev),
    .out_dir   (out_dir),
    .out_z     (out_z)
  );

endmodule
`default_nettype wire

// ===== design/qpc_front.sv =====
`default_nettype none
module qpc_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire qpc_pkg::cfg_wr_t          cfg,
  input  wire logic                      in_valid,
  input  wire logic                      in_cmd,
  input  wire logic                      in_a,
  input  wire logic                      in_b,
  input  wire logic                      in_z,
  input  wire logic                      q_ready,
  output qpc_pkg::op_t                   op
);

  logic [1:0]             prev_ab;
  logic                   invert;
  logic                   index_present;
  logic                   enabled;
  logic [1:0]             ab;
  logic [qpc_pkg::DIR_W-1:0] d;
  logic                   accept;

  assign ab     = {in_a, in_b};
  assign d      = qpc_pkg::step_lookup(prev_ab, ab);
  assign accept = in_valid && q_ready;

  always_comb begin
    op.kind     = in_cmd ? qpc_pkg::OP_ZERO : qpc_pkg::OP_TICK;
    op.has_step = !in_cmd && enabled && (d != qpc_pkg::DIR_NONE);
    op.step_up  = (d == qpc_pkg::DIR_UP) ^ invert;
    op.z_load   = !in_cmd && enabled && index_present;
    op.z_val    = in_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab       <= 2'b00;
      invert        <= 1'b0;
      index_present <= 1'b0;
      enabled       <= 1'b0;
    end else begin
      if (cfg.wr) begin
        case (cfg.idx)
          qpc_pkg::CFG_INVERT:  invert        <= cfg.data[0];
          qpc_pkg::CFG_INDEX:   index_present <= cfg.data[0];
          qpc_pkg::CFG_ENABLED: enabled       <= cfg.data[0];
          default: ;
        endcase
      end
      // capture AB on a zero command or a valid step
      if (accept && (in_cmd || op.has_step)) begin
        prev_ab <= ab;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/qpc_queue.sv =====
`default_nettype none
module qpc_queue #(
  parameter int unsigned DEPTH = qpc_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire qpc_pkg::op_t in_op,
  output logic              out_valid,
  input  wire logic         out_ready,
  output qpc_pkg::op_t      out_op
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  qpc_pkg::op_t  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != '0);
  assign out_op    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/qpc_back.sv =====
`default_nettype none
module qpc_back #(
  parameter int unsigned EDGES_PER_COUNT = qpc_pkg::EDGES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire qpc_pkg::cfg_wr_t              cfg,
  input  wire logic                          op_valid,
  output logic                               op_ready,
  input  wire qpc_pkg::op_t                  op,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [qpc_pkg::PPR_W-1:0]          out_pos,
  output logic [qpc_pkg::REV_W-1:0]          out_rev,
  output logic [qpc_pkg::DIR_W-1:0]          out_dir,
  output logic                               out_z
);

  localparam int unsigned EW = $clog2(EDGES_PER_COUNT) + 2;
  localparam logic signed [EW-1:0] EMAX = EW'(EDGES_PER_COUNT);

  logic [qpc_pkg::PPR_W-1:0] ppr;
  logic signed [EW-1:0]      edge_sum;
  logic [qpc_pkg::PPR_W-1:0] pos;
  logic [qpc_pkg::REV_W-1:0] rev;
  logic [qpc_pkg::DIR_W-1:0] dir;
  logic                      z;

  logic signed [EW-1:0]      edge_sum_next;
  logic [qpc_pkg::PPR_W-1:0] pos_next;
  logic [qpc_pkg::REV_W-1:0] rev_next;
  logic [qpc_pkg::DIR_W-1:0] dir_next;
  logic                      z_next;
  logic signed [EW-1:0]      sum;
  logic [qpc_pkg::PPR_W:0]   pos_inc;
  logic [qpc_pkg::PPR_W-1:0] ppr_new;
  logic                      take;

  assign op_ready = !out_valid || out_ready;
  assign take     = op_valid && op_ready;
  assign pos_inc  = {1'b0, pos} + 17'd1;
  assign sum      = edge_sum + (op.step_up ? EW'(1) : -EW'(1));
  assign ppr_new  = (cfg.data == '0) ? qpc_pkg::PPR_W'(1) : cfg.data;

  always_comb begin
    edge_sum_next = edge_sum;
    pos_next      = pos;
    rev_next      = rev;
    dir_next      = dir;
    z_next        = z;
    case (op.kind)
      qpc_pkg::OP_ZERO: begin
        edge_sum_next = '0;
        pos_next      = '0;
        rev_next      = '0;
        dir_next      = qpc_pkg::DIR_NONE;
      end
      default: begin
        if (op.has_step) begin
          dir_next      = op.step_up ? qpc_pkg::DIR_UP : qpc_pkg::DIR_DOWN;
          edge_sum_next = sum;
          if (sum >= EMAX) begin
            edge_sum_next = sum - EMAX;
            if (pos_inc >= {1'b0, ppr}) begin
              pos_next = '0;
              rev_next = rev + 32'd1;
            end else begin
              pos_next = pos_inc[qpc_pkg::PPR_W-1:0];
            end
          end else if (sum <= -EMAX) begin
            edge_sum_next = sum + EMAX;
            if (pos == '0) begin
              pos_next = ppr - 16'd1;
              rev_next = rev - 32'd1;
            end else begin
              pos_next = pos - 16'd1;
            end
          end
        end
        if (op.z_load) begin
          z_next = op.z_val;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr       <= qpc_pkg::PPR_RESET;
      edge_sum  <= '0;
      pos       <= '0;
      rev       <= '0;
      dir       <= qpc_pkg::DIR_NONE;
      z         <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.wr && (cfg.idx == qpc_pkg::CFG_PPR)) begin
        ppr      <= ppr_new;
        edge_sum <= '0;
        if (pos >= ppr_new) begin
          pos <= '0;
        end
      end else if (take) begin
        edge_sum <= edge_sum_next;
        pos      <= pos_next;
        rev      <= rev_next;
        dir      <= dir_next;
        z        <= z_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (take) begin
      out_pos <= pos_next;
      out_rev <= rev_next;
      out_dir <= dir_next;
      out_z   <= z_next;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_quadrature_position_counter_top.sv =====
`default_nettype none
module tb_quadrature_position_counter_top;
  import qpc_pkg::*;

  localparam int EDGES = EDGES_DEFAULT;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  // Step per {prev_ab, ab}, with ab = A*2+B.
  localparam int STEP_OF [16] = '{ 0, -1,  1,  0,
                                   1,  0,  0, -1,
                                  -1,  0,  0,  1,
                                   0,  1, -1,  0};
  // Gray order of AB for one forward direction.
  localparam logic [1:0] GRAY [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

  typedef struct packed {
    logic [PPR_W-1:0] count;
    logic [REV_W-1:0] rev;
    logic [DIR_W-1:0] dir;
    logic             z;
  } position_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [0] level_a, [1] level_b, [2] level_z
  logic                  s_tuser;   // [0] cmd
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [15:0] count_in_rev, [47:16] rev_count,
                                    // [49:48] last_dir, [50] index_seen
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  quadrature_position_counter_top #(
    .EDGES_PER_COUNT(EDGES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predicted block state and registers
  logic [PPR_W-1:0] ppr_q;
  logic             invert_q;
  logic             index_q;
  logic             enabled_q;
  logic [1:0]       ab_q;
  int               edges_q;
  logic [PPR_W-1:0] pos_q;
  logic [REV_W-1:0] rev_q;
  logic [DIR_W-1:0] dir_q;
  logic             z_q;

  position_t expected_positions[$];
  int        error_count = 0;
  bit        tx_steady = 0;
  bit        rx_steady = 0;
  int        hold_cycles = 0;
  bit        holding = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void advance_position(op_kind_t op, logic a, logic b, logic z);
    logic [1:0] ab;
    int d;
    position_t p;
    ab = {a, b};
    if (op == OP_ZERO) begin
      pos_q = '0;
      rev_q = '0;
      dir_q = DIR_NONE;
      edges_q = 0;
      ab_q = ab;
    end else if (enabled_q) begin
      d = STEP_OF[{ab_q, ab}];
      if (d != 0) begin
        if (invert_q) d = -d;
        edges_q += d;
        if (edges_q >= EDGES) begin
          edges_q -= EDGES;
          if ({1'b0, pos_q} + 17'd1 >= {1'b0, ppr_q}) begin
            pos_q = '0;
            rev_q = rev_q + 32'd1;
          end else begin
            pos_q = pos_q + 16'd1;
          end
        end else if (edges_q <= -EDGES) begin
          edges_q += EDGES;
          if (pos_q == '0) begin
            pos_q = ppr_q - 16'd1;
            rev_q = rev_q - 32'd1;
          end else begin
            pos_q = pos_q - 16'd1;
          end
        end
        dir_q = (d > 0) ? DIR_UP : DIR_DOWN;
        ab_q = ab;
      end
      if (index_q) z_q = z;
    end
    p.count = pos_q;
    p.rev = rev_q;
    p.dir = dir_q;
    p.z = z_q;
    expected_positions.push_back(p);
  endfunction

  function automatic void update_registers(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PPR: begin
        ppr_q = (val == '0) ? 16'd1 : val;
        if (pos_q >= ppr_q) pos_q = '0;
        edges_q = 0;
      end
      CFG_INVERT:  invert_q = val[0];
      CFG_INDEX:   index_q = val[0];
      CFG_ENABLED: enabled_q = val[0];
      default: ;
    endcase
  endfunction

  task automatic send_item(op_kind_t op, logic a, logic b, logic z);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(IN_DATA_W-3){1'b0}}, z, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_position(op, a, b, z);
  endtask

  // Move the encoder one edge forward (dir > 0) or back from its current AB.
  task automatic step_encoder(int dir, logic z);
    int i;
    logic [1:0] nxt;
    i = 0;
    while (GRAY[i] != ab_q) i++;
    nxt = GRAY[(i + dir + 4) % 4];
    send_item(OP_TICK, nxt[1], nxt[0], z);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    update_registers(idx, val);
  endtask

  // Disabled after reset: ticks change nothing, zero still acts.
  task automatic test_reset_state();
    send_item(OP_TICK, 1'b1, 1'b1, 1'b1);
    send_item(OP_TICK, 1'b0, 1'b1, 1'b0);
    send_item(OP_ZERO, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_counting();
    write_reg(CFG_ENABLED, 16'd1);
    write_reg(CFG_INDEX, 16'd1);
    // Wrap down below zero, then back up across it.
    repeat (4) step_encoder(-1, 1'($urandom_range(0, 1)));
    repeat (4) step_encoder(1, 1'($urandom_range(0, 1)));
    send_item(OP_TICK, ab_q[1], ab_q[0], 1'b1);
    send_item(OP_TICK, ~ab_q[1], ~ab_q[0], 1'b0);
  endtask

  task automatic test_wrap_extremes();
    write_reg(CFG_PPR, 16'd0);
    write_reg(CFG_INVERT, 16'd1);
    write_reg(CFG_INDEX, 16'd0);
    repeat (4) step_encoder(-1, 1'b1);
    write_reg(CFG_INVERT, 16'd0);
    write_reg(CFG_PPR, 16'hffff);
    repeat (4) step_encoder(-1, 1'b0);
    // Clamp the position, and drop partial edges on a ppr write.
    write_reg(CFG_PPR, 16'd3);
    repeat (2) step_encoder(1, 1'b1);
    write_reg(CFG_PPR, 16'd3);
    repeat (2) step_encoder(1, 1'b0);
    send_item(OP_ZERO, 1'b0, 1'b1, 1'b0);
    write_reg(CFG_ENABLED, 16'd0);
    step_encoder(1, 1'b1);
    write_reg(CFG_ENABLED, 16'd1);
  endtask

  // Hold the output long enough that the block stalls its input.
  task automatic test_backpressure();
    write_reg(CFG_PPR, 16'd2);
    tx_steady = 1;
    hold_cycles = 300;
    while (!holding) @(posedge clk);
    repeat (40) step_encoder(1, 1'($urandom_range(0, 1)));
    tx_steady = 0;
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] ppr_val;
    int left;
    int seg_len;
    int kind;
    int dir;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: ppr_val = 16'd1;
        1: ppr_val = 16'd0;
        2: ppr_val = 16'hffff;
        3: ppr_val = 16'd2;
        4: ppr_val = 16'd3;
        5: ppr_val = 16'($urandom_range(4, 16));
        6: ppr_val = 16'd5;
        default: ppr_val = 16'($urandom_range(1, 40));
      endcase
      write_reg(CFG_PPR, ppr_val);
      write_reg(CFG_INVERT, (16'($urandom) & 16'hfffe) | 16'(phase % 2));
      write_reg(CFG_INDEX, (16'($urandom) & 16'hfffe) | 16'((phase / 2) % 2));
      write_reg(CFG_ENABLED, (16'($urandom) & 16'hfffe) | 16'(phase != 5));
      left = PHASE_ITEMS;
      while (left > 0) begin
        seg_len = $urandom_range(1, 30);
        if (seg_len > left) seg_len = left;
        left -= seg_len;
        kind = $urandom_range(0, 99);
        dir = $urandom_range(0, 1) ? 1 : -1;
        tx_steady = ($urandom_range(0, 9) == 0);
        rx_steady = ($urandom_range(0, 9) == 0);
        repeat (seg_len) begin
          if ($urandom_range(0, 99) < 2) begin
            send_item(OP_ZERO, 1'($urandom), 1'($urandom), 1'($urandom));
          end else if (kind < 75) begin
            if ($urandom_range(0, 9) == 0) dir = -dir;
            step_encoder(dir, 1'($urandom_range(0, 1)));
          end else begin
            send_item(OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom));
          end
        end
      end
      tx_steady = 0;
      rx_steady = 0;
    end
  endtask

  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        m_tready <= 1'b0;
        holding = 1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        holding = 0;
      end else if (rx_steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
        repeat (pick_gap(1'b0) + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    position_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata[31:0], '0);
      end else begin
        want = expected_positions.pop_front();
        if (m_tdata[15:0] !== want.count)
          report_mismatch("count_in_rev", 32'(m_tdata[15:0]), 32'(want.count));
        if (m_tdata[47:16] !== want.rev)
          report_mismatch("rev_count", m_tdata[47:16], want.rev);
        if (m_tdata[49:48] !== want.dir)
          report_mismatch("last_dir", 32'(m_tdata[49:48]), 32'(want.dir));
        if (m_tdata[50] !== want.z)
          report_mismatch("index_seen", 32'(m_tdata[50]), 32'(want.z));
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PPR;
    cfg_data <= '0;
    ppr_q = PPR_RESET;
    invert_q = 1'b0;
    index_q = 1'b0;
    enabled_q = 1'b0;
    ab_q = 2'd0;
    edges_q = 0;
    pos_q = '0;
    rev_q = '0;
    dir_q = DIR_NONE;
    z_q = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_counting();
    test_wrap_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/qpc_pkg.sv
design/qpc_front.sv
design/qpc_queue.sv
design/qpc_back.sv
design/quadrature_position_counter_top.sv
test/tb_quadrature_position_counter_top.sv
